// ===== hdl/itp_pkg.sv =====
// Shared types, constants and character tables for the infix to postfix converter.
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic [3:0] {
        CODE_NONE   = 4'd0,
        CODE_ADD    = 4'd1,
        CODE_SUB    = 4'd2,
        CODE_MUL    = 4'd3,
        CODE_DIV    = 4'd4,
        CODE_MOD    = 4'd5,
        CODE_POW    = 4'd6,
        CODE_OPEN_P = 4'd7,
        CODE_OPEN_B = 4'd8,
        CODE_OPEN_C = 4'd9,
        CODE_CLOSE_P = 4'd10,
        CODE_CLOSE_B = 4'd11,
        CODE_CLOSE_C = 4'd12
    } op_code_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MISMATCH = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_OVERFLOW = 3'd4
    } err_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       last;
        logic       end_flag;
        err_t       err;
    } result_t;

    function automatic op_code_t classify(input logic [7:0] c);
        op_code_t code;
        case (c)
            8'h2B:   code = CODE_ADD;
            8'h2D:   code = CODE_SUB;
            8'h2A:   code = CODE_MUL;
            8'h2F:   code = CODE_DIV;
            8'h25:   code = CODE_MOD;
            8'h5E:   code = CODE_POW;
            8'h28:   code = CODE_OPEN_P;
            8'h5B:   code = CODE_OPEN_B;
            8'h7B:   code = CODE_OPEN_C;
            8'h29:   code = CODE_CLOSE_P;
            8'h5D:   code = CODE_CLOSE_B;
            8'h7D:   code = CODE_CLOSE_C;
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t code);
        logic [7:0] c;
        case (code)
            CODE_ADD:    c = 8'h2B;
            CODE_SUB:    c = 8'h2D;
            CODE_MUL:    c = 8'h2A;
            CODE_DIV:    c = 8'h2F;
            CODE_MOD:    c = 8'h25;
            CODE_POW:    c = 8'h5E;
            CODE_OPEN_P: c = 8'h28;
            CODE_OPEN_B: c = 8'h5B;
            CODE_OPEN_C: c = 8'h7B;
            default:     c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_op(input op_code_t code);
        return (code >= CODE_ADD) && (code <= CODE_POW);
    endfunction

    function automatic logic is_open(input op_code_t code);
        return (code >= CODE_OPEN_P) && (code <= CODE_OPEN_C);
    endfunction

    function automatic logic is_close(input op_code_t code);
        return (code >= CODE_CLOSE_P) && (code <= CODE_CLOSE_C);
    endfunction

    function automatic logic [1:0] priority_of(input op_code_t code);
        logic [1:0] p;
        case (code) inside
            CODE_POW:                     p = 2'd2;
            CODE_MUL, CODE_DIV, CODE_MOD: p = 2'd1;
            default:                      p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic op_code_t opener_of(input op_code_t code);
        op_code_t o;
        case (code)
            CODE_CLOSE_P: o = CODE_OPEN_P;
            CODE_CLOSE_B: o = CODE_OPEN_B;
            CODE_CLOSE_C: o = CODE_OPEN_C;
            default:      o = CODE_NONE;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/itp_stack_ram.sv =====
// Operator stack memory: one write port, one read port with registered read data.
`default_nettype none

module itp_stack_ram (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire itp_pkg::addr_t   wr_addr,
    input  wire itp_pkg::op_code_t wr_data,
    input  wire itp_pkg::addr_t   rd_addr,
    output itp_pkg::op_code_t     rd_data
);
    import itp_pkg::*;

    op_code_t mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/infix_to_postfix_converter_core.sv =====
// Top level of the infix to postfix converter: shunting yard sequencer around a stack memory.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_ready  | in_char, in_last
//  out     | output    | out_valid/out_ready| out_char, char_valid, run_last, expr_end,
//          |           |                    | error_code
//
// An item passes through the accept, process and done steps, plus a step for each operator popped ahead
// of the item's own step and for each entry popped in the final flush. Any pop that leaves the
// stack non-empty adds a step to read the new top from the memory's registered read port.
// The last item of an expression adds a step for the end result.
// Results pass through a one-deep holding stage and an output register, so the sequencer stalls
// only when both are full and out_ready is low. Reset clears control state only; the stack
// memory is not cleared, since an entry is never read before it has been pushed.
`default_nettype none

module infix_to_postfix_converter_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_char,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_char,
    output logic            char_valid,
    output logic            run_last,
    output logic            expr_end,
    output logic [2:0]      error_code
);
    import itp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MAIN  = 5'b00010,
        S_FLUSH = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t   state_reg, state_next;
    state_t   ret_reg, ret_next;
    logic [7:0] char_reg, char_next;
    logic     last_reg, last_next;
    op_code_t code_reg, code_next;
    count_t   cnt_reg, cnt_next;
    err_t     err_reg, err_next;
    logic     open_reg, open_next;
    op_code_t top_reg, top_next;
    logic     pend_valid_reg, pend_valid_next;
    result_t  pend_reg, pend_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;

    logic     mem_we;
    addr_t    mem_wr_addr;
    op_code_t mem_wr_data;
    addr_t    mem_rd_addr;
    op_code_t mem_rd_data;

    logic     out_free;
    logic     emit_ok;
    logic     emit;
    result_t  emit_data;
    count_t   cnt_m2;
    state_t   finish_st;
    state_t   after_pop_st;

    itp_stack_ram u_stack (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_char   = out_reg.ch;
    assign char_valid = out_reg.ch_valid;
    assign run_last   = out_reg.last;
    assign expr_end   = out_reg.end_flag;
    assign error_code = out_reg.err;

    assign out_free    = !out_valid_reg || out_ready;
    assign emit_ok     = !pend_valid_reg || out_free;
    assign cnt_m2      = cnt_reg - count_t'(2);
    // The entry below the current top is read on every cycle, ready for a pop.
    assign mem_rd_addr = cnt_m2[ADDR_W-1:0];
    assign finish_st   = last_reg ? S_FLUSH : S_DONE;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        code_next       = code_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        open_next       = open_reg;
        top_next        = top_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_wr_addr     = cnt_reg[ADDR_W-1:0];
        mem_wr_data     = code_reg;
        emit            = 1'b0;
        emit_data       = '{ch: 8'h00, ch_valid: 1'b0, last: 1'b0, end_flag: 1'b0,
                            err: ERR_NONE};
        after_pop_st    = (cnt_reg > count_t'(1)) ? S_FETCH : state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    char_next  = in_char;
                    last_next  = in_last;
                    code_next  = classify(in_char);
                    state_next = S_MAIN;
                end
            end

            S_MAIN:
            begin
                if (err_reg != ERR_NONE || char_reg == CHAR_SPACE)
                begin
                    state_next = finish_st;
                end
                else if (is_op(code_reg) && cnt_reg != '0 && is_op(top_reg) &&
                         priority_of(top_reg) >= priority_of(code_reg))
                begin
                    if (emit_ok)
                    begin
                        emit               = 1'b1;
                        emit_data.ch       = code_char(top_reg);
                        emit_data.ch_valid = 1'b1;
                        cnt_next           = cnt_reg - count_t'(1);
                        ret_next           = S_MAIN;
                        state_next         = after_pop_st;
                    end
                end
                else if (is_op(code_reg) || is_open(code_reg))
                begin
                    if (cnt_reg >= count_t'(STACK_DEPTH))
                    begin
                        err_next = ERR_OVERFLOW;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        top_next = code_reg;
                        cnt_next = cnt_reg + count_t'(1);
                    end
                    state_next = finish_st;
                end
                else if (is_close(code_reg))
                begin
                    if (cnt_reg == '0)
                    begin
                        err_next   = ERR_EMPTY;
                        state_next = finish_st;
                    end
                    else if (is_op(top_reg))
                    begin
                        if (emit_ok)
                        begin
                            emit               = 1'b1;
                            emit_data.ch       = code_char(top_reg);
                            emit_data.ch_valid = 1'b1;
                            cnt_next           = cnt_reg - count_t'(1);
                            ret_next           = S_MAIN;
                            state_next         = after_pop_st;
                        end
                    end
                    else if (top_reg == opener_of(code_reg))
                    begin
                        cnt_next   = cnt_reg - count_t'(1);
                        ret_next   = finish_st;
                        state_next = (cnt_reg > count_t'(1)) ? S_FETCH : finish_st;
                    end
                    else
                    begin
                        err_next   = ERR_MISMATCH;
                        state_next = finish_st;
                    end
                end
                else
                begin
                    // Operand: passed straight through.
                    if (emit_ok)
                    begin
                        emit               = 1'b1;
                        emit_data.ch       = char_reg;
                        emit_data.ch_valid = 1'b1;
                        state_next         = finish_st;
                    end
                end
            end

            S_FLUSH:
            begin
                if (err_reg == ERR_NONE && cnt_reg != '0)
                begin
                    if (!is_op(top_reg) || emit_ok)
                    begin
                        if (is_op(top_reg))
                        begin
                            emit               = 1'b1;
                            emit_data.ch       = code_char(top_reg);
                            emit_data.ch_valid = 1'b1;
                        end
                        else
                        begin
                            open_next = 1'b1;
                        end
                        cnt_next   = cnt_reg - count_t'(1);
                        ret_next   = S_FLUSH;
                        state_next = after_pop_st;
                    end
                end
                else if (emit_ok)
                begin
                    emit               = 1'b1;
                    emit_data.end_flag = 1'b1;
                    if (err_reg != ERR_NONE)
                    begin
                        emit_data.err = err_reg;
                    end
                    else if (open_reg)
                    begin
                        emit_data.err = ERR_UNCLOSED;
                    end
                    cnt_next   = '0;
                    err_next   = ERR_NONE;
                    open_next  = 1'b0;
                    state_next = S_DONE;
                end
            end

            S_FETCH:
            begin
                top_next   = mem_rd_data;
                state_next = ret_reg;
            end

            S_DONE:
            begin
                // The held result is the item's final one.
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_MAIN;
            cnt_reg        <= '0;
            err_reg        <= ERR_NONE;
            open_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            open_reg       <= open_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        code_reg <= code_next;
        top_reg  <= top_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

// ===== hdl/itp_checker.sv =====
// Port-level checks for the infix to postfix converter, bound to the top level.
`default_nettype none

module itp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_char,
    input wire logic       char_valid,
    input wire logic       run_last,
    input wire logic       expr_end,
    input wire logic [2:0] error_code
);
    import itp_pkg::*;

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(expr_end))
        else $error("result item changed while stalled");

    // The end-of-expression item always closes the run of its input item.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expr_end |-> run_last)
        else $error("end item without run_last");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid |-> !expr_end && error_code == ERR_NONE)
        else $error("character item carries end flag or error");

    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> expr_end && out_char == 8'h00)
        else $error("non-character item is not a clean end item");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expr_end |-> error_code <= ERR_OVERFLOW)
        else $error("error code out of range");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .char_valid (char_valid),
    .run_last   (run_last),
    .expr_end   (expr_end),
    .error_code (error_code)
);

`default_nettype wire
